// File: rtl/core/weighted_random_index_select_macros.svh
// ----------------------------------------------------------------------------
// Weighted random index select: assertion macros
// Clocked assertion helpers used by the top level of the selector.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_INDEX_SELECT_MACROS_SVH
`define WEIGHTED_RANDOM_INDEX_SELECT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define WRS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define WRS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRS_ASSERT(name, prop, msg)
`define WRS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: rtl/core/wrsel_pkg.sv
// ----------------------------------------------------------------------------
// Weighted random index select: package
// Default parameters, fixed field widths and the scan status type.
// ----------------------------------------------------------------------------
package wrsel_pkg;

	localparam int NUM_WEIGHTS_DEF = 8;
	localparam int RANDOM_BITS_DEF = 15;
	localparam int WEIGHT_BITS_DEF = 16;

	// Fixed widths of the item fields.
	localparam int COUNT_W    = 4;
	localparam int INDEX_W    = 3;
	localparam int OUT_DATA_W = 8;

	// Internal pick index, wide enough for the largest weight count.
	localparam int PICK_W = 4;

	typedef struct packed {
		logic              valid;
		logic              done;
		logic [PICK_W-1:0] pick;
	} scan_stat_t;

endpackage

// File: rtl/core/wrsel_sum_cell.sv
// ----------------------------------------------------------------------------
// Weighted random index select: total cell
// Adds its own weight to the running total when that weight is active.
// ----------------------------------------------------------------------------
module wrsel_sum_cell #(
	parameter int NUM_WEIGHTS = wrsel_pkg::NUM_WEIGHTS_DEF,
	parameter int RANDOM_BITS = wrsel_pkg::RANDOM_BITS_DEF,
	parameter int WEIGHT_BITS = wrsel_pkg::WEIGHT_BITS_DEF,
	parameter int INDEX       = 0,
	parameter int CNT_W       = 4,
	parameter int SUM_W       = 19
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic [RANDOM_BITS-1:0]           in_rand,
	input  logic [CNT_W-1:0]                 in_cnt,
	input  logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] in_weights,
	input  logic [SUM_W-1:0]                 in_total,
	output logic                             out_valid,
	output logic [RANDOM_BITS-1:0]           out_rand,
	output logic [CNT_W-1:0]                 out_cnt,
	output logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] out_weights,
	output logic [SUM_W-1:0]                 out_total
);

	logic [WEIGHT_BITS-1:0] weight;
	logic [SUM_W-1:0]       addend;

	assign weight = in_weights[INDEX*WEIGHT_BITS +: WEIGHT_BITS];
	assign addend = (CNT_W'(INDEX) < in_cnt) ? SUM_W'(weight) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rand    <= in_rand;
			out_cnt     <= in_cnt;
			out_weights <= in_weights;
			out_total   <= in_total + addend;
		end
	end

endmodule

// File: rtl/core/wrsel_scale.sv
// ----------------------------------------------------------------------------
// Weighted random index select: target scaling
// Two stages: split product of random word and total, then the shifted sum.
// ----------------------------------------------------------------------------
module wrsel_scale #(
	parameter int NUM_WEIGHTS = wrsel_pkg::NUM_WEIGHTS_DEF,
	parameter int RANDOM_BITS = wrsel_pkg::RANDOM_BITS_DEF,
	parameter int WEIGHT_BITS = wrsel_pkg::WEIGHT_BITS_DEF,
	parameter int CNT_W       = 4,
	parameter int SUM_W       = 19
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic [RANDOM_BITS-1:0]           in_rand,
	input  logic [CNT_W-1:0]                 in_cnt,
	input  logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] in_weights,
	input  logic [SUM_W-1:0]                 in_total,
	output logic                             out_valid,
	output logic [CNT_W-1:0]                 out_cnt,
	output logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] out_weights,
	output logic [SUM_W-1:0]                 out_target
);

	localparam int HALF_W = (SUM_W + 1) / 2;
	localparam int PROD_W = RANDOM_BITS + HALF_W;
	localparam int FULL_W = RANDOM_BITS + 2 * HALF_W;

	logic [2*HALF_W-1:0]                total_ext;
	logic [PROD_W-1:0]                  p_hi_s1;
	logic [PROD_W-1:0]                  p_lo_s1;
	logic                               valid_s1;
	logic [CNT_W-1:0]                   cnt_s1;
	logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] weights_s1;
	logic [FULL_W-1:0]                  full_prod;

	assign total_ext = (2*HALF_W)'(in_total);
	// The product is below 2^FULL_W, so the recombining add cannot carry out.
	assign full_prod = FULL_W'({p_hi_s1, {HALF_W{1'b0}}}) + FULL_W'(p_lo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_hi_s1     <= PROD_W'(in_rand) * PROD_W'(total_ext[2*HALF_W-1:HALF_W]);
			p_lo_s1     <= PROD_W'(in_rand) * PROD_W'(total_ext[HALF_W-1:0]);
			cnt_s1      <= in_cnt;
			weights_s1  <= in_weights;
			out_cnt     <= cnt_s1;
			out_weights <= weights_s1;
			out_target  <= full_prod[RANDOM_BITS +: SUM_W];
		end
	end

endmodule

// File: rtl/core/wrsel_scan_cell.sv
// ----------------------------------------------------------------------------
// Weighted random index select: scan cell
// Extends the running prefix sum and claims the pick on the first crossing.
// ----------------------------------------------------------------------------
module wrsel_scan_cell #(
	parameter int NUM_WEIGHTS = wrsel_pkg::NUM_WEIGHTS_DEF,
	parameter int WEIGHT_BITS = wrsel_pkg::WEIGHT_BITS_DEF,
	parameter int INDEX       = 0,
	parameter int CNT_W       = 4,
	parameter int SUM_W       = 19
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  wrsel_pkg::scan_stat_t            in_stat,
	input  logic [CNT_W-1:0]                 in_cnt,
	input  logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] in_weights,
	input  logic [SUM_W-1:0]                 in_target,
	input  logic [SUM_W-1:0]                 in_run,
	output wrsel_pkg::scan_stat_t            out_stat,
	output logic [CNT_W-1:0]                 out_cnt,
	output logic [NUM_WEIGHTS*WEIGHT_BITS-1:0] out_weights,
	output logic [SUM_W-1:0]                 out_target,
	output logic [SUM_W-1:0]                 out_run
);

	logic [WEIGHT_BITS-1:0] weight;
	logic                   active;
	logic [SUM_W-1:0]       run_next;
	logic                   hit;

	assign weight   = in_weights[INDEX*WEIGHT_BITS +: WEIGHT_BITS];
	assign active   = CNT_W'(INDEX) < in_cnt;
	assign run_next = active ? in_run + SUM_W'(weight) : in_run;
	assign hit      = !in_stat.done && active && (in_target < run_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stat <= '0;
		end else if (adv) begin
			out_stat.valid <= in_stat.valid;
			out_stat.done  <= in_stat.done || hit;
			out_stat.pick  <= hit ? wrsel_pkg::PICK_W'(INDEX) : in_stat.pick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cnt     <= in_cnt;
			out_weights <= in_weights;
			out_target  <= in_target;
			out_run     <= run_next;
		end
	end

endmodule

// File: rtl/core/weighted_random_index_select.sv
// ----------------------------------------------------------------------------
// Weighted random index select (roulette-wheel selection)
// Picks the first index whose prefix weight sum exceeds a scaled random draw.
// ----------------------------------------------------------------------------
// Input beats on s_* carry a random word, an active weight count and
// NUM_WEIGHTS weights; each beat yields exactly one output beat on m_*.
// m_tuser is the found flag, m_tdata the chosen index (zero when not found).
// A count above NUM_WEIGHTS is treated as NUM_WEIGHTS.
// The datapath is a row of NUM_WEIGHTS total cells, a two-stage scaling
// multiplier and a row of NUM_WEIGHTS scan cells, all of them registered.
// One beat is accepted per cycle for as long as the output side takes beats.
// When the receiver stalls with a result held on m_*, the whole row of cells
// holds and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "weighted_random_index_select_macros.svh"

module weighted_random_index_select #(
	parameter int NUM_WEIGHTS = wrsel_pkg::NUM_WEIGHTS_DEF,
	parameter int RANDOM_BITS = wrsel_pkg::RANDOM_BITS_DEF,
	parameter int WEIGHT_BITS = wrsel_pkg::WEIGHT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// random_value, active_count, weight_0 .. weight_(NUM_WEIGHTS-1), zero fill
	input  logic [((RANDOM_BITS + wrsel_pkg::COUNT_W + NUM_WEIGHTS*WEIGHT_BITS + 7)/8)*8-1:0]
		s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// chosen_index, zero fill
	output logic [wrsel_pkg::OUT_DATA_W-1:0] m_tdata,
	// found
	output logic m_tuser
);

	localparam int CNT_W = $clog2(NUM_WEIGHTS + 1);
	localparam int SUM_W = WEIGHT_BITS + $clog2(NUM_WEIGHTS);
	localparam int WV_W  = NUM_WEIGHTS * WEIGHT_BITS;
	localparam int CNT_LSB = RANDOM_BITS;
	localparam int W_LSB   = RANDOM_BITS + wrsel_pkg::COUNT_W;

	logic                          adv;
	logic [wrsel_pkg::COUNT_W-1:0] in_count;
	logic [CNT_W-1:0]              in_cnt_sat;

	logic                   sum_valid   [0:NUM_WEIGHTS];
	logic [RANDOM_BITS-1:0] sum_rand    [0:NUM_WEIGHTS];
	logic [CNT_W-1:0]       sum_cnt     [0:NUM_WEIGHTS];
	logic [WV_W-1:0]        sum_weights [0:NUM_WEIGHTS];
	logic [SUM_W-1:0]       sum_total   [0:NUM_WEIGHTS];

	wrsel_pkg::scan_stat_t  scan_stat    [0:NUM_WEIGHTS];
	logic [CNT_W-1:0]       scan_cnt     [0:NUM_WEIGHTS];
	logic [WV_W-1:0]        scan_weights [0:NUM_WEIGHTS];
	logic [SUM_W-1:0]       scan_target  [0:NUM_WEIGHTS];
	logic [SUM_W-1:0]       scan_run     [0:NUM_WEIGHTS];
	logic                   scale_valid;

	// The last scan cell is the output register; the row moves when it is free.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	assign in_count   = s_tdata[CNT_LSB +: wrsel_pkg::COUNT_W];
	assign in_cnt_sat = ({1'b0, in_count} > (wrsel_pkg::COUNT_W+1)'(NUM_WEIGHTS))
		? CNT_W'(NUM_WEIGHTS) : CNT_W'(in_count);

	assign sum_valid[0]   = s_tvalid;
	assign sum_rand[0]    = s_tdata[RANDOM_BITS-1:0];
	assign sum_cnt[0]     = in_cnt_sat;
	assign sum_weights[0] = s_tdata[W_LSB +: WV_W];
	assign sum_total[0]   = '0;

	for (genvar i = 0; i < NUM_WEIGHTS; i++) begin : g_sum
		wrsel_sum_cell #(
			.NUM_WEIGHTS (NUM_WEIGHTS),
			.RANDOM_BITS (RANDOM_BITS),
			.WEIGHT_BITS (WEIGHT_BITS),
			.INDEX       (i),
			.CNT_W       (CNT_W),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.in_valid    (sum_valid[i]),
			.in_rand     (sum_rand[i]),
			.in_cnt      (sum_cnt[i]),
			.in_weights  (sum_weights[i]),
			.in_total    (sum_total[i]),
			.out_valid   (sum_valid[i+1]),
			.out_rand    (sum_rand[i+1]),
			.out_cnt     (sum_cnt[i+1]),
			.out_weights (sum_weights[i+1]),
			.out_total   (sum_total[i+1])
		);
	end

	wrsel_scale #(
		.NUM_WEIGHTS (NUM_WEIGHTS),
		.RANDOM_BITS (RANDOM_BITS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (sum_valid[NUM_WEIGHTS]),
		.in_rand     (sum_rand[NUM_WEIGHTS]),
		.in_cnt      (sum_cnt[NUM_WEIGHTS]),
		.in_weights  (sum_weights[NUM_WEIGHTS]),
		.in_total    (sum_total[NUM_WEIGHTS]),
		.out_valid   (scale_valid),
		.out_cnt     (scan_cnt[0]),
		.out_weights (scan_weights[0]),
		.out_target  (scan_target[0])
	);

	always_comb begin
		scan_stat[0]       = '0;
		scan_stat[0].valid = scale_valid;
	end
	assign scan_run[0] = '0;

	for (genvar i = 0; i < NUM_WEIGHTS; i++) begin : g_scan
		wrsel_scan_cell #(
			.NUM_WEIGHTS (NUM_WEIGHTS),
			.WEIGHT_BITS (WEIGHT_BITS),
			.INDEX       (i),
			.CNT_W       (CNT_W),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.in_stat     (scan_stat[i]),
			.in_cnt      (scan_cnt[i]),
			.in_weights  (scan_weights[i]),
			.in_target   (scan_target[i]),
			.in_run      (scan_run[i]),
			.out_stat    (scan_stat[i+1]),
			.out_cnt     (scan_cnt[i+1]),
			.out_weights (scan_weights[i+1]),
			.out_target  (scan_target[i+1]),
			.out_run     (scan_run[i+1])
		);
	end

	// With a nonzero total the target stays below it, so some cell always hits.
	assign m_tvalid = scan_stat[NUM_WEIGHTS].valid;
	assign m_tuser  = scan_stat[NUM_WEIGHTS].done;
	assign m_tdata  = wrsel_pkg::OUT_DATA_W'(
		scan_stat[NUM_WEIGHTS].pick[wrsel_pkg::INDEX_W-1:0]);

	`WRS_ASSERT(a_pick_in_range, scan_stat[NUM_WEIGHTS].done |-> (scan_stat[NUM_WEIGHTS].pick < wrsel_pkg::PICK_W'(NUM_WEIGHTS)), "pick beyond weight count")
	`WRS_ASSERT(a_miss_is_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "index not zero on a miss")
	`WRS_ASSERT(a_found_means_total, (m_tvalid && m_tuser) |-> (scan_run[NUM_WEIGHTS] != '0), "found with zero total")
	`WRS_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready, "input taken while output stalled")
	`WRS_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid, "output valid after reset")

endmodule

// File: verif/weighted_random_index_select_tb.sv
// ----------------------------------------------------------------------------
// Weighted random index select: testbench
// Drives directed and random weight sets through the selector. Each result beat
// is checked against a typed or roulette-wheel pick, under three idle patterns.
// ----------------------------------------------------------------------------
module weighted_random_index_select_tb;

	localparam int NUM_W   = wrsel_pkg::NUM_WEIGHTS_DEF;
	localparam int RAND_W  = wrsel_pkg::RANDOM_BITS_DEF;
	localparam int WGT_W   = wrsel_pkg::WEIGHT_BITS_DEF;
	localparam int DATA_W  = ((RAND_W + wrsel_pkg::COUNT_W + NUM_W*WGT_W + 7)/8)*8;
	localparam int LATENCY = 2*NUM_W + 2;
	localparam int DIR_N   = 16;
	localparam int RAND_N  = 1000;
	localparam int QUIET_LIMIT = 4000;

	localparam logic [RAND_W-1:0] RVAL_FULL = '1;
	localparam logic [WGT_W-1:0]  WGT_MAX   = '1;

	// Same layout as s_tdata below the zero fill: random word lowest, weight 0 next
	// above the count.
	typedef struct packed {
		logic [NUM_W-1:0][WGT_W-1:0]       w;
		logic [wrsel_pkg::COUNT_W-1:0]     count;
		logic [RAND_W-1:0]                 rand_val;
	} item_t;

	typedef struct packed {
		logic                          found;
		logic [wrsel_pkg::INDEX_W-1:0] idx;
	} result_t;

	typedef struct packed {
		logic [RAND_W-1:0]             rand_val;
		logic [wrsel_pkg::COUNT_W-1:0] count;
		logic [0:NUM_W-1][WGT_W-1:0]   w;
		logic                          typed;
		result_t                       res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [wrsel_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	// Typed expectation riding along with the beat on s_*.
	logic    note_typed = 1'b0;
	result_t note_res = '0;

	int send_idle_pct = 9;
	int recv_idle_pct = 86;
	int fails = 0;
	int quiet_cycles = 0;
	result_t pending_picks[$];
	dir_row_t directed_tab [DIR_N];

	weighted_random_index_select DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic result_t roulette_pick(input item_t it);
		result_t r;
		int unsigned n;
		longint unsigned total, target, run, rv;
		r = '0;
		n = (it.count > NUM_W) ? NUM_W : it.count;
		total = 0;
		for (int i = 0; i < n; i++)
			total += it.w[i];
		if (total == 0)
			return r;
		rv = it.rand_val;
		target = (rv * total) >> RAND_W;
		run = 0;
		for (int i = 0; i < n; i++) begin
			run += it.w[i];
			if (target < run) begin
				r.idx = wrsel_pkg::INDEX_W'(i);
				break;
			end
		end
		r.found = 1'b1;
		return r;
	endfunction

	function automatic item_t draw_item();
		item_t it;
		int wstyle;
		case ($urandom_range(9))
			0: it.rand_val = '0;
			1: it.rand_val = RVAL_FULL;
			default: it.rand_val = RAND_W'($urandom);
		endcase
		case ($urandom_range(19))
			0: it.count = '0;
			1, 2, 3: it.count = wrsel_pkg::COUNT_W'($urandom_range(15, NUM_W + 1));
			default: it.count = wrsel_pkg::COUNT_W'($urandom_range(NUM_W, 1));
		endcase
		wstyle = $urandom_range(3);
		for (int i = 0; i < NUM_W; i++) begin
			case (wstyle)
				0: it.w[i] = WGT_W'($urandom);
				1: it.w[i] = WGT_W'($urandom_range(3));
				2: it.w[i] = ($urandom_range(3) == 0) ? WGT_W'($urandom) : '0;
				default: it.w[i] = $urandom_range(1) ? WGT_MAX : '0;
			endcase
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input logic typed, input result_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(it);
		note_typed <= typed;
		note_res <= res;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Expectations are queued on the input beat and consumed on the output beat.
	always @(posedge clk) begin
		result_t got, want;
		logic s_beat, m_beat;
		if (arst_n) begin
			s_beat = s_tvalid && s_tready;
			m_beat = m_tvalid && m_tready;
			if (s_beat)
				pending_picks.push_back(note_typed ? note_res :
					roulette_pick(item_t'(s_tdata[$bits(item_t)-1:0])));
			if (m_beat) begin
				got.found = m_tuser;
				got.idx = m_tdata[wrsel_pkg::INDEX_W-1:0];
				if (pending_picks.size() == 0) begin
					$error("unexpected result beat: found=%0d chosen_index=%0d",
						got.found, got.idx);
					fails++;
				end else begin
					want = pending_picks.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						fails++;
					end
					if (got.idx !== want.idx) begin
						$error("chosen_index: expected %0d, actual %0d", want.idx, got.idx);
						fails++;
					end
				end
			end
			if (s_beat || m_beat)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		item_t it;
		directed_tab = '{
			// Zero count, and all weights zero: not found.
			'{RVAL_FULL, 4'd0, '{default: WGT_MAX}, 1'b1, '{1'b0, 3'd0}},
			'{RVAL_FULL, 4'd8, '{default: '0}, 1'b1, '{1'b0, 3'd0}},
			// Count above the number of weights is saturated.
			'{'0, 4'd15, '{default: WGT_MAX}, 1'b1, '{1'b1, 3'd0}},
			'{RVAL_FULL, 4'd8, '{default: WGT_MAX}, 1'b1, '{1'b1, 3'd7}},
			'{RVAL_FULL, 4'd1, '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
				1'b1, '{1'b1, 3'd0}},
			'{'0, 4'd8, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1},
				1'b1, '{1'b1, 3'd7}},
			// The only nonzero weight lies beyond the count.
			'{RVAL_FULL, 4'd7, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF},
				1'b1, '{1'b0, 3'd0}},
			'{15'h4000, 4'd12, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1},
				1'b1, '{1'b1, 3'd7}},
			'{15'h3FFF, 4'd2, '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
				1'b0, '0},
			'{15'h4000, 4'd2, '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
				1'b0, '0},
			'{15'h4000, 4'd4, '{16'd5, 16'd0, 16'd0, 16'd5, 16'd9, 16'd9, 16'd9, 16'd9},
				1'b0, '0},
			'{15'h5555, 4'd8, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
				16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
			'{15'h2AAA, 4'd8, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
				16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
			'{15'h1234, 4'd3, '{16'd0, 16'd0, 16'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				16'hFFFF, 16'hFFFF}, 1'b0, '0},
			'{RVAL_FULL, 4'd8, '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
				1'b0, '0},
			'{'0, 4'd1, '{default: WGT_MAX}, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_N; k++) begin
			it.rand_val = directed_tab[k].rand_val;
			it.count = directed_tab[k].count;
			for (int i = 0; i < NUM_W; i++)
				it.w[i] = directed_tab[k].w[i];
			send_item(it, directed_tab[k].typed, directed_tab[k].res);
		end

		for (int k = 0; k < RAND_N; k++) begin
			if (k == RAND_N/3) begin
				send_idle_pct = 86;
				recv_idle_pct = 9;
			end else if (k == 2*RAND_N/3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_item(draw_item(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (2*LATENCY) @(posedge clk);

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
